>>> design/fpws_pkg.sv
// Package for the flash page-write splitter.
// Holds field widths, page geometry, the controller state type and the
// command and status structs shared by the controller and the datapath.
package fpws_pkg;

   localparam int PAGE_SIZE  = 256;
   localparam int PAGE_BITS  = $clog2(PAGE_SIZE);
   localparam int ADDR_W     = 24;
   localparam int COUNT_W    = 14;
   localparam int CHUNK_W    = PAGE_BITS + 1;
   localparam int MAX_LENGTH = 8192;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

>>> design/fpws_ctrl.sv
// Controller state machine of the flash page-write splitter.
// Depends on fpws_pkg for the state type and the command and status structs.
module fpws_ctrl
   import fpws_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            busy        = 1'b1;
            rsp_valid   = 1'b1;
            cmd.advance = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/fpws_datapath.sv
// Datapath of the flash page-write splitter: address, remaining count and
// buffer offset registers plus the per-chunk length logic. Depends on fpws_pkg.
module fpws_datapath
   import fpws_pkg::*;
(
   input  logic                clock,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [ADDR_W-1:0]   req_start_address,
   input  logic [COUNT_W-1:0]  req_byte_count,
   output logic [ADDR_W-1:0]   rsp_chunk_address,
   output logic [CHUNK_W-1:0]  rsp_chunk_length,
   output logic [COUNT_W-1:0]  rsp_buffer_offset,
   output logic                rsp_last_chunk
);

   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  addr_in;
   logic [COUNT_W-1:0] remaining_ff;
   logic [COUNT_W-1:0] remaining_in;
   logic [COUNT_W-1:0] offset_ff;
   logic [COUNT_W-1:0] offset_in;
   logic [CHUNK_W-1:0] room;
   logic [CHUNK_W-1:0] chunk_len;
   logic               last;

   assign room      = CHUNK_W'(PAGE_SIZE) - CHUNK_W'(addr_ff[PAGE_BITS-1:0]);
   assign last      = remaining_ff <= COUNT_W'(room);
   assign chunk_len = last ? remaining_ff[CHUNK_W-1:0] : room;

   always_comb begin
      addr_in      = addr_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      if (cmd.load) begin
         addr_in      = req_start_address;
         remaining_in = (req_byte_count > COUNT_W'(MAX_LENGTH)) ?
                        COUNT_W'(MAX_LENGTH) : req_byte_count;
         offset_in    = '0;
      end else if (cmd.advance) begin
         addr_in      = addr_ff + ADDR_W'(chunk_len);
         remaining_in = remaining_ff - COUNT_W'(chunk_len);
         offset_in    = offset_ff + COUNT_W'(chunk_len);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      remaining_ff <= remaining_in;
      offset_ff    <= offset_in;
   end

   assign status.last       = last;
   assign rsp_chunk_address = addr_ff;
   assign rsp_chunk_length  = chunk_len;
   assign rsp_buffer_offset = offset_ff;
   assign rsp_last_chunk    = last;

endmodule

>>> design/flash_page_write_splitter_core.sv
// Top level of the flash page-write splitter.
// A request taken on start while busy is low is cut into page-program chunks,
// one chunk per cycle on the rsp_ ports marked by rsp_valid, beginning the
// cycle after the transfer. A request of N chunks (N is 1 for a zero length,
// at most 33 for 8192 bytes) keeps busy high up to and including its last
// chunk; the datapath advances one chunk per cycle. The receiver cannot
// stall, and each chunk is shown for exactly one cycle.
// Depends on fpws_pkg, fpws_ctrl and fpws_datapath.
module flash_page_write_splitter_core
   import fpws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ADDR_W-1:0]  req_start_address,
   input  logic [COUNT_W-1:0] req_byte_count,
   output logic               rsp_valid,
   output logic [ADDR_W-1:0]  rsp_chunk_address,
   output logic [CHUNK_W-1:0] rsp_chunk_length,
   output logic [COUNT_W-1:0] rsp_buffer_offset,
   output logic               rsp_last_chunk
);

   dp_cmd_type    cmd;
   dp_status_type status;

   fpws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   fpws_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .status            (status),
      .req_start_address (req_start_address),
      .req_byte_count    (req_byte_count),
      .rsp_chunk_address (rsp_chunk_address),
      .rsp_chunk_length  (rsp_chunk_length),
      .rsp_buffer_offset (rsp_buffer_offset),
      .rsp_last_chunk    (rsp_last_chunk)
   );

endmodule

>>> design/fpws_checker.sv
// Port-level checker for the flash page-write splitter and its bind to the
// top level. Depends on fpws_pkg.
module fpws_checker
   import fpws_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [ADDR_W-1:0]  rsp_chunk_address,
   input logic [CHUNK_W-1:0] rsp_chunk_length,
   input logic [COUNT_W-1:0] rsp_buffer_offset,
   input logic               rsp_last_chunk
);

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid && rsp_buffer_offset == '0)
      else $error("first chunk missing or offset not zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_chunk |=> rsp_valid
         && rsp_chunk_address == ADDR_W'($past(rsp_chunk_address)
                                         + ADDR_W'($past(rsp_chunk_length))))
      else $error("chunk address does not follow previous chunk");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_chunk |=>
         rsp_buffer_offset == COUNT_W'($past(rsp_buffer_offset)
                                       + COUNT_W'($past(rsp_chunk_length))))
      else $error("buffer offset does not follow previous chunk");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_chunk |=> !busy && !rsp_valid)
      else $error("block still busy after the last chunk");

endmodule

bind flash_page_write_splitter_core fpws_checker u_fpws_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_chunk_address (rsp_chunk_address),
   .rsp_chunk_length  (rsp_chunk_length),
   .rsp_buffer_offset (rsp_buffer_offset),
   .rsp_last_chunk    (rsp_last_chunk)
);

>>> tb/tb_top.sv
// Self-checking testbench for flash_page_write_splitter_core.
// Sends write requests and checks each page chunk against a local predictor.
// Depends on fpws_pkg and the splitter RTL only.
module tb_top
   import fpws_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [CHUNK_W-1:0] length;
      logic [COUNT_W-1:0] offset;
      logic               last;
   } page_chunk_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [ADDR_W-1:0]  req_start_address;
   logic [COUNT_W-1:0] req_byte_count;
   logic               rsp_valid;
   logic [ADDR_W-1:0]  rsp_chunk_address;
   logic [CHUNK_W-1:0] rsp_chunk_length;
   logic [COUNT_W-1:0] rsp_buffer_offset;
   logic               rsp_last_chunk;

   page_chunk_type expected_chunks[$];
   int unsigned mismatch_count;
   int unsigned request_count;
   int unsigned chunk_count;
   int unsigned stall_cycles;
   bit          idle_enabled;

   flash_page_write_splitter_core DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_address (req_start_address),
      .req_byte_count    (req_byte_count),
      .rsp_valid         (rsp_valid),
      .rsp_chunk_address (rsp_chunk_address),
      .rsp_chunk_length  (rsp_chunk_length),
      .rsp_buffer_offset (rsp_buffer_offset),
      .rsp_last_chunk    (rsp_last_chunk)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void split_request(input logic [ADDR_W-1:0] start_addr,
                                         input logic [COUNT_W-1:0] byte_count);
      logic [ADDR_W-1:0] addr;
      int unsigned       remaining;
      int unsigned       offset;
      int unsigned       room;
      int unsigned       chunk_bytes;
      page_chunk_type    chunk;
      remaining = (byte_count > MAX_LENGTH) ? MAX_LENGTH : byte_count;
      addr = start_addr;
      offset = 0;
      do begin
         room = PAGE_SIZE - (addr % PAGE_SIZE);
         chunk_bytes = (remaining < room) ? remaining : room;
         remaining -= chunk_bytes;
         chunk.address = addr;
         chunk.length = chunk_bytes[CHUNK_W-1:0];
         chunk.offset = offset[COUNT_W-1:0];
         chunk.last = (remaining == 0);
         expected_chunks.push_back(chunk);
         offset += chunk_bytes;
         addr = addr + chunk_bytes[ADDR_W-1:0];
      end while (remaining != 0);
   endfunction

   task automatic check_chunk();
      page_chunk_type seen;
      page_chunk_type want;
      seen = '{rsp_chunk_address, rsp_chunk_length, rsp_buffer_offset, rsp_last_chunk};
      chunk_count++;
      if (expected_chunks.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: unexpected chunk addr %h len %0d off %0d last %b",
                     seen.address, seen.length, seen.offset, seen.last);
      end else begin
         want = expected_chunks.pop_front();
         if (seen.address !== want.address || seen.length !== want.length ||
             seen.offset !== want.offset || seen.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                        want.address, want.length, want.offset, want.last,
                        seen.address, seen.length, seen.offset, seen.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid)
            check_chunk();
         if (start && !busy) begin
            split_request(req_start_address, req_byte_count);
            request_count++;
         end
         if (rsp_valid || (start && !busy))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [ADDR_W-1:0] addr,
                               input logic [COUNT_W-1:0] byte_count);
      start <= 1'b1;
      req_start_address <= addr;
      req_byte_count <= byte_count;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap();
      if (idle_enabled && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         req_start_address <= ADDR_W'($urandom);
         req_byte_count <= COUNT_W'($urandom);
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic send_and_idle(input logic [ADDR_W-1:0] addr,
                                input logic [COUNT_W-1:0] byte_count);
      send_request(addr, byte_count);
      idle_gap();
   endtask

   task automatic test_zero_length();
      send_and_idle(24'h000000, 14'd0);
      send_and_idle(24'hFFFFFF, 14'd0);
      send_and_idle(24'h5A3C81, 14'd0);
   endtask

   task automatic test_page_aligned();
      send_and_idle(24'h000000, 14'd1);
      send_and_idle(24'h001000, 14'd256);
      send_and_idle(24'h123400, 14'd512);
      send_and_idle(24'h000000, 14'(MAX_LENGTH));
   endtask

   task automatic test_unaligned_start();
      send_and_idle(24'h0000FF, 14'd2);
      send_and_idle(24'h000001, 14'd255);
      send_and_idle(24'h0A0B80, 14'd300);
      send_and_idle(24'h3C5D01, 14'(MAX_LENGTH));
   endtask

   task automatic test_length_saturation();
      send_and_idle(24'h000000, 14'(MAX_LENGTH + 1));
      send_and_idle(24'h2A5533, 14'h3FFF);
      send_and_idle(24'hD5AACC, 14'h2AAA);
   endtask

   task automatic test_address_wrap();
      send_and_idle(24'hFFFFF0, 14'd100);
      send_and_idle(24'hFFFF00, 14'd256);
      send_and_idle(24'hFFFFFF, 14'(MAX_LENGTH));
      send_and_idle(24'hFFF080, 14'h1555);
   endtask

   task automatic test_random(input int unsigned items);
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] byte_count;
      for (int unsigned i = 0; i < items; i++) begin
         idle_enabled = (i < items * 3 / 4);
         addr = ADDR_W'($urandom);
         case ($urandom_range(0, 5))
            0: addr = ADDR_W'(24'hFFFFFF - $urandom_range(0, 600));
            1: addr[PAGE_BITS-1:0] = '0;
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: byte_count = COUNT_W'($urandom_range(0, 700));
            5:             byte_count = COUNT_W'($urandom_range(0, 16383));
            6:             byte_count = COUNT_W'(MAX_LENGTH);
            7:             byte_count = COUNT_W'($urandom_range(0, 2));
            default:       byte_count = COUNT_W'($urandom_range(700, MAX_LENGTH));
         endcase
         send_and_idle(addr, byte_count);
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_start_address <= '0;
      req_byte_count <= '0;
      mismatch_count = 0;
      request_count = 0;
      chunk_count = 0;
      idle_enabled = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_length();
      test_page_aligned();
      test_unaligned_start();
      test_length_saturation();
      test_address_wrap();
      test_random(100);

      start <= 1'b0;
      do @(posedge clock); while (expected_chunks.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_chunks.size() != 0) begin
         $display("ERROR: %0d expected chunks never arrived", expected_chunks.size());
         mismatch_count += expected_chunks.size();
      end
      $display("Run covered %0d write requests split into %0d page chunks.",
               request_count, chunk_count);
      $display("Requests included zero, saturated, unaligned and wrapping lengths.");
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
design/fpws_pkg.sv
design/fpws_ctrl.sv
design/fpws_datapath.sv
design/flash_page_write_splitter_core.sv
design/fpws_checker.sv
tb/tb_top.sv
